// ----- rtl/core/issp_pkg.sv -----
package issp_pkg;

  // Stream length limit: the byte at this count acts as end of stream
  localparam int STREAM_BYTES = 32768;
  localparam logic [15:0] SC_LIMIT = 16'(STREAM_BYTES - 1);

  // Buffer address width and divider step count
  localparam int ADDR_W = 14;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(ADDR_W);

  // Configuration register indexes
  localparam logic [1:0] CFG_COLUMNS    = 2'd0;
  localparam logic [1:0] CFG_MAX_FIELD  = 2'd1;
  localparam logic [1:0] CFG_ORDER_CODE = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  COLUMNS_RST    = 8'd80;
  localparam logic [15:0] MAX_FIELD_RST  = 16'd32768;
  localparam logic [7:0]  ORDER_CODE_RST = 8'd17;

  // Parser phase
  typedef enum logic [3:0] {
    PH_ATTN    = 4'd0,
    PH_CUR_HI  = 4'd1,
    PH_CUR_LO  = 4'd2,
    PH_ORDER   = 4'd3,
    PH_FLD_HI  = 4'd4,
    PH_FLD_LO  = 4'd5,
    PH_DATA    = 4'd6,
    PH_SKIP    = 4'd7,
    PH_DISCARD = 4'd8
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ATTN      = 3'd0,
    KIND_CURSOR    = 3'd1,
    KIND_FLD_START = 3'd2,
    KIND_FLD_BYTE  = 3'd3,
    KIND_FLD_END   = 3'd4
  } kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic pop;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic plan_div;
    logic div_done;
    logic pend_empty;
    logic pend_last;
    logic out_free;
  } dp_status_t;

  // Six-bit address code table
  localparam logic [7:0] CODE_TABLE [64] = '{
    8'h40, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
    8'hC8, 8'hC9, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
    8'h50, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
    8'hD8, 8'hD9, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
    8'h60, 8'h61, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7,
    8'hE8, 8'hE9, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
    8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
    8'hF8, 8'hF9, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F
  };

  // Reverse lookup of a code byte; unknown codes give 0 (entries are unique)
  function automatic logic [5:0] six_bit_value(input logic [7:0] code);
    logic [5:0] v;
    v = '0;
    for (int i = 0; i < 64; i++) begin
      if (CODE_TABLE[i] == code) begin
        v = v | 6'(i);
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/issp_ctl.sv -----
module issp_ctl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  issp_pkg::dp_status_t  status,
  output issp_pkg::ctl_cmd_t    cmd
);

  issp_pkg::ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= issp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      issp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.plan_div ? issp_pkg::ST_DIV : issp_pkg::ST_EMIT;
        end
      end
      issp_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_nxt = issp_pkg::ST_EMIT;
        end
      end
      issp_pkg::ST_EMIT: begin
        if (status.pend_empty || (status.pend_last && status.out_free)) begin
          state_nxt = issp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = issp_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.pop      = 1'b0;
    case (state_r)
      issp_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      issp_pkg::ST_DIV: begin
        cmd.div_step = !status.div_done;
      end
      issp_pkg::ST_EMIT: begin
        cmd.pop = !status.pend_empty && status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/core/issp_dp.sv -----
module issp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  // request in
  input  logic [7:0]           in_stream_byte,
  input  logic                 in_end_of_stream,
  // configuration
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_byte_value,
  output logic [13:0]          out_row,
  output logic [7:0]           out_column,
  output logic [15:0]          out_field_length,
  output logic                 out_last_of_run,
  // control
  input  issp_pkg::ctl_cmd_t   cmd,
  output issp_pkg::dp_status_t status
);

  // Configuration registers
  logic [7:0]  columns_r;
  logic [15:0] max_field_r;
  logic [7:0]  order_code_r;

  // Parser state
  issp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  hi_addr_r, hi_addr_nxt;
  logic [15:0] field_cnt_r, field_cnt_nxt;
  logic [15:0] stream_cnt_r, stream_cnt_nxt;

  // Divider
  logic [issp_pkg::ADDR_W-1:0]    quo_r;
  logic [7:0]                     rem_r;
  logic [issp_pkg::DIV_CNT_W-1:0] div_cnt_r;

  // Pending results (two slots)
  logic [1:0]  pend_cnt_r;
  logic [2:0]  pk0_r, pk1_r;
  logic [7:0]  pb0_r;
  logic [15:0] pl0_r, pl1_r;
  logic        pd0_r;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic [13:0] out_row_r;
  logic [7:0]  out_col_r;
  logic [15:0] out_len_r;
  logic        out_last_r;

  // Item plan
  logic [1:0]  plan_cnt;
  logic [2:0]  p0_kind, p1_kind;
  logic [7:0]  p0_byte;
  logic [15:0] p0_len, p1_len;
  logic        p0_div;
  logic        plan_div;

  logic        eos;
  logic        is_order;
  logic [15:0] fc_inc;
  logic [7:0]  cols_eff;
  logic        six_coded;
  logic [issp_pkg::ADDR_W-1:0] addr;
  logic [8:0]  rem_sh;
  logic        rem_ge;
  logic        out_free;

  assign eos      = in_end_of_stream || (stream_cnt_r >= issp_pkg::SC_LIMIT);
  assign is_order = (in_stream_byte == order_code_r);
  assign fc_inc   = field_cnt_r + 16'd1;
  assign cols_eff = (columns_r == 8'd0) ? 8'd1 : columns_r;

  // Address decode: six-bit coded pair or 14-bit binary
  assign six_coded = (hi_addr_r[7:6] != 2'b00);
  assign addr = six_coded ?
      {2'b00, issp_pkg::six_bit_value(hi_addr_r), issp_pkg::six_bit_value(in_stream_byte)} :
      {hi_addr_r[5:0], in_stream_byte};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r    <= issp_pkg::COLUMNS_RST;
      max_field_r  <= issp_pkg::MAX_FIELD_RST;
      order_code_r <= issp_pkg::ORDER_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        issp_pkg::CFG_COLUMNS:    columns_r    <= cfg_data[7:0];
        issp_pkg::CFG_MAX_FIELD:  max_field_r  <= cfg_data;
        issp_pkg::CFG_ORDER_CODE: order_code_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Per-byte parse: results planned and next parser state
  always_comb begin
    plan_cnt      = 2'd0;
    p0_kind       = issp_pkg::KIND_ATTN;
    p0_byte       = 8'd0;
    p0_len        = 16'd0;
    p0_div        = 1'b0;
    p1_kind       = issp_pkg::KIND_CURSOR;
    p1_len        = 16'd0;
    plan_div      = 1'b0;
    phase_nxt     = phase_r;
    hi_addr_nxt   = hi_addr_r;
    field_cnt_nxt = field_cnt_r;
    case (phase_r)
      issp_pkg::PH_ATTN: begin
        plan_cnt  = eos ? 2'd2 : 2'd1;
        p0_kind   = issp_pkg::KIND_ATTN;
        p0_byte   = in_stream_byte;
        p1_kind   = issp_pkg::KIND_CURSOR;
        phase_nxt = issp_pkg::PH_CUR_HI;
      end
      issp_pkg::PH_CUR_HI: begin
        hi_addr_nxt = in_stream_byte;
        if (eos) begin
          plan_cnt = 2'd1;
          p0_kind  = issp_pkg::KIND_CURSOR;
        end
        phase_nxt = issp_pkg::PH_CUR_LO;
      end
      issp_pkg::PH_CUR_LO: begin
        plan_cnt  = 2'd1;
        p0_kind   = issp_pkg::KIND_CURSOR;
        p0_div    = 1'b1;
        plan_div  = 1'b1;
        phase_nxt = issp_pkg::PH_ORDER;
      end
      issp_pkg::PH_ORDER: begin
        phase_nxt = is_order ? issp_pkg::PH_FLD_HI : issp_pkg::PH_SKIP;
      end
      issp_pkg::PH_FLD_HI: begin
        hi_addr_nxt = in_stream_byte;
        phase_nxt   = issp_pkg::PH_FLD_LO;
      end
      issp_pkg::PH_FLD_LO: begin
        // a field whose address ends the stream is dropped
        if (!eos) begin
          plan_cnt      = 2'd1;
          p0_kind       = issp_pkg::KIND_FLD_START;
          p0_div        = 1'b1;
          plan_div      = 1'b1;
          field_cnt_nxt = 16'd0;
          phase_nxt     = issp_pkg::PH_DATA;
        end
      end
      issp_pkg::PH_DATA: begin
        if (is_order) begin
          plan_cnt  = 2'd1;
          p0_kind   = issp_pkg::KIND_FLD_END;
          p0_len    = field_cnt_r;
          phase_nxt = issp_pkg::PH_FLD_HI;
        end else if (field_cnt_r < max_field_r) begin
          field_cnt_nxt = fc_inc;
          p0_kind       = issp_pkg::KIND_FLD_BYTE;
          p0_byte       = in_stream_byte;
          p1_kind       = issp_pkg::KIND_FLD_END;
          p1_len        = fc_inc;
          plan_cnt      = eos ? 2'd2 : 2'd1;
        end else if (eos) begin
          // overflow: byte dropped, field still closes
          plan_cnt = 2'd1;
          p0_kind  = issp_pkg::KIND_FLD_END;
          p0_len   = field_cnt_r;
        end
      end
      default: ;
    endcase

    // End of stream handling
    if (in_end_of_stream) begin
      phase_nxt     = issp_pkg::PH_ATTN;
      field_cnt_nxt = 16'd0;
    end else if (eos) begin
      phase_nxt = issp_pkg::PH_DISCARD;
    end
  end

  // Stream byte counter, saturating
  always_comb begin
    if (in_end_of_stream) begin
      stream_cnt_nxt = 16'd0;
    end else if (stream_cnt_r != 16'hFFFF) begin
      stream_cnt_nxt = stream_cnt_r + 16'd1;
    end else begin
      stream_cnt_nxt = stream_cnt_r;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= issp_pkg::PH_ATTN;
      hi_addr_r    <= 8'd0;
      field_cnt_r  <= 16'd0;
      stream_cnt_r <= 16'd0;
    end else if (cmd.accept) begin
      phase_r      <= phase_nxt;
      hi_addr_r    <= hi_addr_nxt;
      field_cnt_r  <= field_cnt_nxt;
      stream_cnt_r <= stream_cnt_nxt;
    end
  end

  // Restoring divider, one quotient bit per step
  assign rem_sh = {rem_r, quo_r[issp_pkg::ADDR_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, cols_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.accept && plan_div) begin
      div_cnt_r <= issp_pkg::DIV_STEPS;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && plan_div) begin
      quo_r <= addr;
      rem_r <= 8'd0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[issp_pkg::ADDR_W-2:0], rem_ge};
      rem_r <= rem_ge ? 8'(rem_sh - {1'b0, cols_eff}) : rem_sh[7:0];
    end
  end

  // Pending result slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
    end else if (cmd.accept) begin
      pend_cnt_r <= plan_cnt;
    end else if (cmd.pop) begin
      pend_cnt_r <= pend_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pk0_r <= p0_kind;
      pb0_r <= p0_byte;
      pl0_r <= p0_len;
      pd0_r <= p0_div;
      pk1_r <= p1_kind;
      pl1_r <= p1_len;
    end else if (cmd.pop) begin
      pk0_r <= pk1_r;
      pb0_r <= 8'd0;
      pl0_r <= pl1_r;
      pd0_r <= 1'b0;
    end
  end

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_kind_r <= pk0_r;
      out_byte_r <= pb0_r;
      out_row_r  <= pd0_r ? quo_r : 14'd0;
      out_col_r  <= pd0_r ? rem_r : 8'd0;
      out_len_r  <= pl0_r;
      out_last_r <= (pend_cnt_r == 2'd1);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte_value   = out_byte_r;
  assign out_row          = out_row_r;
  assign out_column       = out_col_r;
  assign out_field_length = out_len_r;
  assign out_last_of_run  = out_last_r;

  // Status to controller
  assign status.plan_div   = plan_div;
  assign status.div_done   = (div_cnt_r == '0);
  assign status.pend_empty = (pend_cnt_r == 2'd0);
  assign status.pend_last  = (pend_cnt_r == 2'd1);
  assign status.out_free   = out_free;

  // Checks
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r != 2'd3)
    else $error("pending result count out of range");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (pend_cnt_r == 2'd0))
    else $error("request accepted with results still pending");

  a_pop_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (div_cnt_r == '0))
    else $error("result taken while address split still running");

  a_div_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && plan_div) |=> (div_cnt_r == issp_pkg::DIV_STEPS))
    else $error("address split not started");

endmodule

// ----- rtl/core/inbound_screen_stream_parser_unit.sv -----
// Inbound screen stream parser.
// Input channel (in_*): one stream byte per request, in_end_of_stream on the
// last byte. A request is taken when in_valid is high and in_stall is low.
// Result channel (out_*): attention, cursor, field start, field byte and
// field end results, out_last_of_run on the final result of each byte;
// a result is taken when out_valid is high and out_stall is low.
// Configuration channel (cfg_*): index 0 columns, 1 max field bytes,
// 2 set-address order code; always ready, write only while idle.
// Flow: one byte at a time. A byte that carries an address
// low byte runs a 14-step shift-subtract divider by the column count; its
// result is loaded once the divider is done, and the next byte is taken
// after that result has left the pending slots. Other bytes load their
// results without a divider wait. The divider sets the worst-case rate.
// While the receiver stalls, the last result holds in the output register and
// the next byte may still be taken; further results wait in two pending slots,
// and in_stall stays high until they have moved out.
// Reset (rst_n low, synchronous) clears the parser to expect an attention
// byte, drops pending results and restores register defaults.
module inbound_screen_stream_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_end_of_stream,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [13:0] out_row,
  output logic [7:0]  out_column,
  output logic [15:0] out_field_length,
  output logic        out_last_of_run,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  issp_pkg::ctl_cmd_t   cmd;
  issp_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer
  issp_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Parser, divider and result registers
  issp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stream_byte   (in_stream_byte),
    .in_end_of_stream (in_end_of_stream),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_field_length (out_field_length),
    .out_last_of_run  (out_last_of_run),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

// ----- dv/inbound_screen_stream_parser_unit_tb.sv -----
`timescale 1ns / 1ps

module inbound_screen_stream_parser_unit_tb;

  // Quiet stretch allowed before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to wait once nothing is expected: covers the address split
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 270;
  localparam int STREAMS_PER_SETTING = 3;

  // Six-bit buffer address codes, indexed by value
  localparam logic [7:0] SCREEN_CODES [64] = '{
    8'h40, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
    8'hC8, 8'hC9, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
    8'h50, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
    8'hD8, 8'hD9, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
    8'h60, 8'h61, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7,
    8'hE8, 8'hE9, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
    8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
    8'hF8, 8'hF9, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F
  };

  typedef struct packed {
    issp_pkg::kind_t kind;
    logic [7:0]      value;
    logic [13:0]     row;
    logic [7:0]      col;
    logic [15:0]     len;
    logic            last;
  } parse_result_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_stream_byte;
  logic        in_end_of_stream;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte_value;
  logic [13:0] out_row;
  logic [7:0]  out_column;
  logic [15:0] out_field_length;
  logic        out_last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Parser model state and registers
  issp_pkg::phase_t prs_phase;
  logic [7:0]  addr_hi;
  logic [13:0] pend_row;
  logic [7:0]  pend_col;
  int unsigned fld_count;
  int unsigned strm_count;
  logic [7:0]  reg_columns;
  logic [15:0] reg_max_field;
  logic [7:0]  reg_order;
  logic [5:0]  six_of [256];

  parse_result_t pending_results[$];
  logic [7:0]    stream_buf[$];

  // Bookkeeping
  int mismatches = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int live_items = 0;
  int streams_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  // Traffic shaping
  bit          sender_gaps = 1'b0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run = 0;
  bit          stall_hold = 1'b0;

  inbound_screen_stream_parser_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_field_length (out_field_length),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 99) < 40);
      end
      default: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 10);
          stall_hold = !stall_hold;
        end else begin
          stall_run--;
        end
        out_stall <= stall_hold;
      end
    endcase
  end

  // Result checker; outputs are stable at the falling edge before the taking edge
  always @(negedge clk) begin
    parse_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d byte %02h row %0d col %0d len %0d last %0b",
                 $time, out_kind, out_byte_value, out_row, out_column, out_field_length,
                 out_last_of_run);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_kind !== exp_res.kind || out_byte_value !== exp_res.value ||
            out_row !== exp_res.row || out_column !== exp_res.col ||
            out_field_length !== exp_res.len || out_last_of_run !== exp_res.last) begin
          mismatches++;
          $display("%0t: expected kind %0d byte %02h row %0d col %0d len %0d last %0b", $time,
                   exp_res.kind, exp_res.value, exp_res.row, exp_res.col, exp_res.len,
                   exp_res.last);
          $display("%0t:   actual kind %0d byte %02h row %0d col %0d len %0d last %0b", $time,
                   out_kind, out_byte_value, out_row, out_column, out_field_length,
                   out_last_of_run);
        end
      end
    end
  end

  // Watchdog: any request, result or register write moving counts as progress
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, pending_results.size());
      $display("inbound_screen_stream_parser_unit_tb failed");
      $finish;
    end
  end

  function automatic parse_result_t make_result(issp_pkg::kind_t k, logic [7:0] v,
                                                logic [13:0] r, logic [7:0] c,
                                                logic [15:0] len);
    parse_result_t res;
    res.kind = k;
    res.value = v;
    res.row = r;
    res.col = c;
    res.len = len;
    res.last = 1'b0;
    return res;
  endfunction

  // Address pair to row/column; six-bit coded when either top bit of the high byte is set
  task automatic split_address(input logic [7:0] hi, input logic [7:0] lo);
    int unsigned addr;
    int unsigned cols;
    cols = (reg_columns == 0) ? 1 : reg_columns;
    if ((hi & 8'hC0) != 0) begin
      addr = six_of[hi] * 64 + six_of[lo];
    end else begin
      addr = {hi, lo};
    end
    pend_row = 14'(addr / cols);
    pend_col = 8'(addr % cols);
  endtask

  // Predict the results of one accepted byte and queue them
  task automatic parse_byte(input logic [7:0] b, input logic real_end);
    parse_result_t run[$];
    logic eos;
    eos = real_end || (strm_count + 1 >= issp_pkg::STREAM_BYTES);
    case (prs_phase)
      issp_pkg::PH_ATTN: begin
        run.push_back(make_result(issp_pkg::KIND_ATTN, b, '0, '0, '0));
        if (eos) run.push_back(make_result(issp_pkg::KIND_CURSOR, '0, '0, '0, '0));
        prs_phase = issp_pkg::PH_CUR_HI;
      end
      issp_pkg::PH_CUR_HI: begin
        addr_hi = b;
        if (eos) run.push_back(make_result(issp_pkg::KIND_CURSOR, '0, '0, '0, '0));
        prs_phase = issp_pkg::PH_CUR_LO;
      end
      issp_pkg::PH_CUR_LO: begin
        split_address(addr_hi, b);
        run.push_back(make_result(issp_pkg::KIND_CURSOR, '0, pend_row, pend_col, '0));
        prs_phase = issp_pkg::PH_ORDER;
      end
      issp_pkg::PH_ORDER: begin
        prs_phase = (b == reg_order) ? issp_pkg::PH_FLD_HI : issp_pkg::PH_SKIP;
      end
      issp_pkg::PH_FLD_HI: begin
        addr_hi = b;
        prs_phase = issp_pkg::PH_FLD_LO;
      end
      issp_pkg::PH_FLD_LO: begin
        // a field whose address ends the stream is dropped
        if (!eos) begin
          split_address(addr_hi, b);
          run.push_back(make_result(issp_pkg::KIND_FLD_START, '0, pend_row, pend_col, '0));
          fld_count = 0;
          prs_phase = issp_pkg::PH_DATA;
        end
      end
      issp_pkg::PH_DATA: begin
        if (b == reg_order) begin
          run.push_back(make_result(issp_pkg::KIND_FLD_END, '0, '0, '0, 16'(fld_count)));
          prs_phase = issp_pkg::PH_FLD_HI;
        end else begin
          if (fld_count < reg_max_field) begin
            run.push_back(make_result(issp_pkg::KIND_FLD_BYTE, b, '0, '0, '0));
            fld_count++;
          end
          if (eos) begin
            run.push_back(make_result(issp_pkg::KIND_FLD_END, '0, '0, '0,
                                      16'(fld_count)));
          end
        end
      end
      default: begin
      end
    endcase
    if (strm_count < 16'hFFFF) strm_count++;
    if (real_end) begin
      prs_phase = issp_pkg::PH_ATTN;
      strm_count = 0;
      fld_count = 0;
    end else if (eos) begin
      prs_phase = issp_pkg::PH_DISCARD;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_results.push_back(run[i]);
  endtask

  // One request on the input channel, with bursty sender gaps
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_stream_byte <= b;
    in_end_of_stream <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (prs_phase != issp_pkg::PH_SKIP && prs_phase != issp_pkg::PH_DISCARD) live_items++;
    bytes_sent++;
    parse_byte(b, last);
  endtask

  task automatic send_stream();
    foreach (stream_buf[i]) send_byte(stream_buf[i], i == stream_buf.size() - 1);
    streams_sent++;
  endtask

  // Wait for every expected result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    bit done;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      done = cfg_ready;
      @(posedge clk);
    end while (!done);
  endtask

  task automatic set_regs(input logic [7:0] cols, input logic [15:0] max_bytes,
                          input logic [7:0] order);
    settle();
    write_reg(issp_pkg::CFG_COLUMNS, 16'(cols));
    write_reg(issp_pkg::CFG_MAX_FIELD, max_bytes);
    write_reg(issp_pkg::CFG_ORDER_CODE, 16'(order));
    cfg_valid <= 1'b0;
    reg_columns = cols;
    reg_max_field = max_bytes;
    reg_order = order;
    settings_used++;
  endtask

  function automatic logic [7:0] field_data();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == reg_order);
    return v;
  endfunction

  // Coded, binary or arbitrary high-bit address pair
  task automatic add_address();
    case ($urandom_range(0, 2))
      0: begin
        stream_buf.push_back(SCREEN_CODES[$urandom_range(0, 63)]);
        stream_buf.push_back(SCREEN_CODES[$urandom_range(0, 63)]);
      end
      1: begin
        stream_buf.push_back(8'($urandom_range(0, 63)));
        stream_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        stream_buf.push_back(8'($urandom_range(64, 255)));
        stream_buf.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Mostly well-formed streams with random content; some cut short or broken
  task automatic build_random_stream();
    int cut;
    stream_buf.delete();
    stream_buf.push_back(8'($urandom_range(0, 255)));
    add_address();
    repeat ($urandom_range(0, 4)) begin
      stream_buf.push_back(reg_order);
      add_address();
      repeat ($urandom_range(0, 6)) stream_buf.push_back(field_data());
    end
    if ($urandom_range(0, 9) == 0) stream_buf.push_back(reg_order);
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, stream_buf.size());
        while (stream_buf.size() > cut) void'(stream_buf.pop_back());
      end
      1: begin
        // junk where the first order belongs
        stream_buf.insert(3, field_data());
      end
      default: begin
      end
    endcase
  endtask

  task automatic test_short_streams();
    set_regs(8'd80, 16'd32768, 8'h11);
    stall_mode = STALL_RANDOM;
    stream_buf = '{8'h00};
    send_stream();
    stream_buf = '{8'hFF, 8'h3F};
    send_stream();
  endtask

  task automatic test_fields_and_addresses();
    // binary cursor at the top of the range, coded field address, order closing the stream
    stream_buf = '{8'h7D, 8'h3F, 8'hFF, 8'h11, 8'h5D, 8'h7F, 8'hC1, 8'h11};
    send_stream();
    // unknown codes read as zero; a non-order byte stops parsing
    stream_buf = '{8'hF1, 8'hFF, 8'h00, 8'h22, 8'h11};
    send_stream();
  endtask

  task automatic test_overflow_and_zero_columns();
    set_regs(8'd0, 16'd1, 8'h11);
    sender_gaps = 1'b1;
    stall_mode = STALL_RUNS;
    // second data byte dropped; a field whose address ends the stream gives nothing
    stream_buf = '{8'h7D, 8'h00, 8'h05, 8'h11, 8'h00, 8'h80, 8'hAA, 8'hBB, 8'h11, 8'h40};
    send_stream();
  endtask

  task automatic test_random_streams();
    int target;
    int n;
    target = live_items + RANDOM_ITEMS;
    n = 0;
    while (live_items < target) begin
      if (n % STREAMS_PER_SETTING == 0) begin
        case (n / STREAMS_PER_SETTING)
          0: set_regs(8'd255, 16'd0, 8'hFF);
          1: set_regs(8'd1, 16'd32768, 8'h00);
          default: begin
            case ($urandom_range(0, 3))
              0: set_regs(8'($urandom_range(0, 1)), 16'($urandom_range(0, 8)),
                          8'($urandom_range(0, 255)));
              1: set_regs(8'd255, 16'd32768, 8'($urandom_range(0, 255)));
              default: set_regs(8'($urandom_range(1, 255)), 16'($urandom_range(0, 8)),
                                8'($urandom_range(0, 255)));
            endcase
          end
        endcase
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      build_random_stream();
      send_stream();
      n++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stream_byte = '0;
    in_end_of_stream = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = issp_pkg::CFG_COLUMNS;
    cfg_data = '0;
    foreach (six_of[i]) six_of[i] = '0;
    foreach (SCREEN_CODES[i]) six_of[SCREEN_CODES[i]] = 6'(i);
    prs_phase = issp_pkg::PH_ATTN;
    addr_hi = '0;
    pend_row = '0;
    pend_col = '0;
    fld_count = 0;
    strm_count = 0;
    reg_columns = issp_pkg::COLUMNS_RST;
    reg_max_field = issp_pkg::MAX_FIELD_RST;
    reg_order = issp_pkg::ORDER_CODE_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_short_streams();
    test_fields_and_addresses();
    test_overflow_and_zero_columns();
    test_random_streams();
    settle();

    $display("Ran %0d streams (%0d bytes) over %0d register settings, %0d results checked.",
             streams_sent, bytes_sent, settings_used, results_checked);
    $display("Streams included short, dropped-field, overflow and zero-column cases.");
    if (mismatches == 0) begin
      $display("inbound_screen_stream_parser_unit_tb passed");
    end else begin
      $display("inbound_screen_stream_parser_unit_tb failed");
    end
    $finish;
  end

endmodule
